>>> rtl/apiwsc_pkg.sv
`timescale 1ns / 1ps
package apiwsc_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int ENC_BITS_DEF  = 16;

    localparam int VAL_W   = 48;
    localparam int ACC_W   = 52;
    localparam int SP_W    = 24;
    localparam int PWM_W   = 16;
    localparam int SPD_W   = 24;
    localparam int RATE_W  = 32;
    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 5;
    localparam int M_DATA_W = 88;
    localparam int HOLD_LIMIT = 40000;

    localparam int STEP_W    = 6;
    localparam int LAST_STEP = 32;
    localparam int SH_W      = 6;

    localparam logic signed [VAL_W-1:0] C_FILT_A = 48'sd4188881604;
    localparam logic signed [VAL_W-1:0] C_FILT_B = 48'sd106042743;
    localparam logic signed [VAL_W-1:0] C_M1     = 48'sd8250632176;
    localparam logic signed [VAL_W-1:0] C_M2     = 48'sd3964254814;
    localparam logic signed [VAL_W-1:0] C_REF_A  = 48'sd5239860;
    localparam logic signed [VAL_W-1:0] C_REF_B  = 48'sd3350074;
    localparam logic signed [VAL_W-1:0] C_KP     = 48'sd330068237;
    localparam logic signed [VAL_W-1:0] C_KI_A   = 48'sd1675037;
    localparam logic signed [VAL_W-1:0] C_KI_B   = 48'sd1073742;
    localparam logic signed [VAL_W-1:0] C_HALF_T = 48'sd21474836;

    localparam logic [RATE_W-1:0] RATE_RST = 32'd214748;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_KP_START, REG_KI_START, REG_RATE_P, REG_RATE_I
    } reg_idx_t;

    typedef enum logic [5:0] {
        S_FS, S_RAW, S_SP, S_MH0, S_MH1, S_EH0, S_EH1, S_KPS0, S_KPS1, S_KIS0, S_KIS1,
        S_PG, S_IG, S_DP, S_EC, S_YM, S_EM, S_DKP, S_DKI, S_T, S_H, S_D1, S_S2, S_ONE,
        S_C_FA, S_C_FB, S_C_M1, S_C_M2, S_C_RA, S_C_RB, S_C_KP, S_C_KIA, S_C_KIB,
        S_C_HALF, S_RATE_P, S_RATE_I
    } src_t;

    typedef enum logic [1:0] {SHS_32, SHS_F, SHS_F8} shs_t;
    typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} accop_t;
    typedef enum logic [3:0] {
        D_NONE, D_FS, D_EC, D_YM, D_EM, D_DKP, D_DKI, D_T, D_PG, D_IG, D_H, D_D1, D_S2,
        D_U, D_SPD
    } dst_t;

    typedef struct packed {
        logic   use_mul;
        src_t   a;
        src_t   b;
        shs_t   sh;
        accop_t op;
        dst_t   dst;
    } uop_t;

    typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_COMMIT, ST_HOLD} state_t;
    typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_RND, PH_FIN} mph_t;

    typedef struct packed {
        logic              capture;
        logic              mul_start;
        logic              apply;
        logic              commit;
        logic              out_load;
        logic              wheel;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0]  kp_start;
        logic [VAL_W-1:0]  ki_start;
        logic [RATE_W-1:0] rate_p;
        logic [RATE_W-1:0] rate_i;
        logic              load_kp;
        logic              load_ki;
    } cfg_t;

    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        if (v > ACC_MAX) begin
            sat48 = VAL_MAX;
        end else if (v < ACC_MIN) begin
            sat48 = VAL_MIN;
        end else begin
            sat48 = v[VAL_W-1:0];
        end
    endfunction

    // per-wheel microprogram
    function automatic uop_t uop(input logic [STEP_W-1:0] step);
        case (step)
            6'd0:  uop = '{1'b1, S_C_FA,   S_FS,   SHS_32, ACC_LOAD, D_NONE};
            6'd1:  uop = '{1'b1, S_C_FB,   S_RAW,  SHS_32, ACC_ADD,  D_FS};
            6'd2:  uop = '{1'b0, S_SP,     S_ONE,  SHS_32, ACC_LOAD, D_NONE};
            6'd3:  uop = '{1'b0, S_FS,     S_ONE,  SHS_32, ACC_SUB,  D_EC};
            6'd4:  uop = '{1'b1, S_C_RA,   S_SP,   SHS_32, ACC_LOAD, D_NONE};
            6'd5:  uop = '{1'b1, S_C_RB,   S_SP,   SHS_32, ACC_ADD,  D_NONE};
            6'd6:  uop = '{1'b1, S_C_M1,   S_MH0,  SHS_32, ACC_ADD,  D_NONE};
            6'd7:  uop = '{1'b1, S_C_M2,   S_MH1,  SHS_32, ACC_SUB,  D_YM};
            6'd8:  uop = '{1'b0, S_FS,     S_ONE,  SHS_32, ACC_LOAD, D_NONE};
            6'd9:  uop = '{1'b0, S_YM,     S_ONE,  SHS_32, ACC_SUB,  D_EM};
            6'd10: uop = '{1'b1, S_C_M1,   S_KPS0, SHS_32, ACC_LOAD, D_NONE};
            6'd11: uop = '{1'b1, S_C_M2,   S_KPS1, SHS_32, ACC_SUB,  D_NONE};
            6'd12: uop = '{1'b1, S_C_KP,   S_EH0,  SHS_32, ACC_ADD,  D_NONE};
            6'd13: uop = '{1'b1, S_C_KP,   S_EH1,  SHS_32, ACC_SUB,  D_DKP};
            6'd14: uop = '{1'b1, S_EM,     S_DKP,  SHS_F,  ACC_LOAD, D_T};
            6'd15: uop = '{1'b0, S_PG,     S_ONE,  SHS_32, ACC_LOAD, D_NONE};
            6'd16: uop = '{1'b1, S_RATE_P, S_T,    SHS_32, ACC_SUB,  D_PG};
            6'd17: uop = '{1'b1, S_C_M1,   S_KIS0, SHS_32, ACC_LOAD, D_NONE};
            6'd18: uop = '{1'b1, S_C_M2,   S_KIS1, SHS_32, ACC_SUB,  D_NONE};
            6'd19: uop = '{1'b1, S_C_KIA,  S_EH0,  SHS_32, ACC_ADD,  D_NONE};
            6'd20: uop = '{1'b1, S_C_KIB,  S_EH1,  SHS_32, ACC_ADD,  D_DKI};
            6'd21: uop = '{1'b1, S_EM,     S_DKI,  SHS_F,  ACC_LOAD, D_T};
            6'd22: uop = '{1'b0, S_IG,     S_ONE,  SHS_32, ACC_LOAD, D_NONE};
            6'd23: uop = '{1'b1, S_RATE_I, S_T,    SHS_32, ACC_SUB,  D_IG};
            6'd24: uop = '{1'b0, S_EC,     S_ONE,  SHS_32, ACC_LOAD, D_NONE};
            6'd25: uop = '{1'b0, S_EH0,    S_ONE,  SHS_32, ACC_SUB,  D_D1};
            6'd26: uop = '{1'b0, S_EC,     S_ONE,  SHS_32, ACC_LOAD, D_NONE};
            6'd27: uop = '{1'b0, S_EH0,    S_ONE,  SHS_32, ACC_ADD,  D_S2};
            6'd28: uop = '{1'b1, S_C_HALF, S_IG,   SHS_32, ACC_LOAD, D_H};
            6'd29: uop = '{1'b0, S_DP,     S_ONE,  SHS_32, ACC_LOAD, D_NONE};
            6'd30: uop = '{1'b1, S_PG,     S_D1,   SHS_F,  ACC_ADD,  D_NONE};
            6'd31: uop = '{1'b1, S_H,      S_S2,   SHS_F,  ACC_ADD,  D_U};
            6'd32: uop = '{1'b1, S_FS,     S_ONE,  SHS_F8, ACC_LOAD, D_SPD};
            default: uop = '{1'b0, S_ONE,  S_ONE,  SHS_32, ACC_LOAD, D_NONE};
        endcase
    endfunction

endpackage

>>> rtl/apiwsc_regs.sv
`timescale 1ns / 1ps
module apiwsc_regs
    import apiwsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [VAL_W-1:0]  kp_reg;
    logic [VAL_W-1:0]  ki_reg;
    logic [RATE_W-1:0] rp_reg;
    logic [RATE_W-1:0] ri_reg;
    logic              wr;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= '0;
            ki_reg <= '0;
            rp_reg <= RATE_RST;
            ri_reg <= RATE_RST;
        end else if (wr) begin
            case (idx)
                REG_KP_START: kp_reg <= pwdata[VAL_W-1:0];
                REG_KI_START: ki_reg <= pwdata[VAL_W-1:0];
                REG_RATE_P:   rp_reg <= pwdata[RATE_W-1:0];
                REG_RATE_I:   ri_reg <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_KP_START: prdata = {{(CFG_W-VAL_W){kp_reg[VAL_W-1]}}, kp_reg};
            REG_KI_START: prdata = {{(CFG_W-VAL_W){ki_reg[VAL_W-1]}}, ki_reg};
            REG_RATE_P:   prdata = {{(CFG_W-RATE_W){1'b0}}, rp_reg};
            REG_RATE_I:   prdata = {{(CFG_W-RATE_W){1'b0}}, ri_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.kp_start = pwdata[VAL_W-1:0];
    assign cfg.ki_start = pwdata[VAL_W-1:0];
    assign cfg.rate_p   = rp_reg;
    assign cfg.rate_i   = ri_reg;
    assign cfg.load_kp  = wr && (idx == REG_KP_START);
    assign cfg.load_ki  = wr && (idx == REG_KI_START);

endmodule

>>> rtl/apiwsc_mul.sv
`timescale 1ns / 1ps
module apiwsc_mul
    import apiwsc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] a,
    input  logic signed [VAL_W-1:0] b,
    input  logic [SH_W-1:0]         sh,
    output logic signed [VAL_W-1:0] res,
    output logic                    done
);

    mph_t                    ph_reg, ph_next;
    logic [1:0]              k_reg, k_next;
    logic                    done_reg;
    logic [VAL_W-1:0]        ma_reg, mb_reg;
    logic                    neg_reg;
    logic [SH_W-1:0]         sh_reg;
    logic [2*VAL_W-1:0]      prod_reg;
    logic [2*VAL_W:0]        rsum_reg;
    logic signed [VAL_W-1:0] res_reg;

    logic [15:0]             chunk;
    logic [VAL_W+15:0]       pp;
    logic [2*VAL_W-1:0]      pp_sh;
    logic [2*VAL_W:0]        rnd;
    logic [2*VAL_W:0]        sv;
    logic [VAL_W-1:0]        lim;
    logic [VAL_W-1:0]        mag;

    always_comb begin
        case (k_reg)
            2'd0:    chunk = mb_reg[15:0];
            2'd1:    chunk = mb_reg[31:16];
            default: chunk = mb_reg[47:32];
        endcase
        pp = ma_reg * chunk;
        case (k_reg)
            2'd0:    pp_sh = {32'b0, pp};
            2'd1:    pp_sh = {16'b0, pp, 16'b0};
            default: pp_sh = {pp, 32'b0};
        endcase
        rnd = (sh_reg == '0) ? '0 : ((2*VAL_W+1)'(1) << (sh_reg - SH_W'(1)));
        sv  = rsum_reg >> sh_reg;
        lim = neg_reg ? VAL_MIN : VAL_MAX;
        mag = (sv > {{(VAL_W+1){1'b0}}, lim}) ? lim : sv[VAL_W-1:0];
    end

    always_comb begin
        ph_next = ph_reg;
        k_next  = k_reg;
        case (ph_reg)
            PH_IDLE: begin
                if (start) begin
                    ph_next = PH_MUL;
                    k_next  = '0;
                end
            end
            PH_MUL: begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2) begin
                    ph_next = PH_RND;
                end
            end
            PH_RND:  ph_next = PH_FIN;
            PH_FIN:  ph_next = PH_IDLE;
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_IDLE;
            k_reg    <= '0;
            done_reg <= 1'b0;
        end else begin
            ph_reg   <= ph_next;
            k_reg    <= k_next;
            done_reg <= (ph_reg == PH_FIN);
        end
    end

    always_ff @(posedge aclk) begin
        case (ph_reg)
            PH_IDLE: begin
                if (start) begin
                    ma_reg   <= a[VAL_W-1] ? VAL_W'(-a) : a;
                    mb_reg   <= b[VAL_W-1] ? VAL_W'(-b) : b;
                    neg_reg  <= a[VAL_W-1] ^ b[VAL_W-1];
                    sh_reg   <= sh;
                    prod_reg <= '0;
                end
            end
            PH_MUL:  prod_reg <= prod_reg + pp_sh;
            PH_RND:  rsum_reg <= {1'b0, prod_reg} + rnd;
            PH_FIN:  res_reg  <= neg_reg ? VAL_W'(-mag) : mag;
            default: ;
        endcase
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

>>> rtl/apiwsc_dp.sv
`timescale 1ns / 1ps
module apiwsc_dp
    import apiwsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ENC_BITS  = ENC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    input  cfg_t                cfg,
    input  logic [ENC_BITS-1:0] enc_count_left,
    input  logic [ENC_BITS-1:0] enc_count_right,
    input  logic [SP_W-1:0]     setpoint_left,
    input  logic [SP_W-1:0]     setpoint_right,
    output logic                mul_done,
    output logic [PWM_W-1:0]    pwm_left,
    output logic                reverse_left,
    output logic [PWM_W-1:0]    pwm_right,
    output logic                reverse_right,
    output logic [SPD_W-1:0]    speed_left,
    output logic [SPD_W-1:0]    speed_right
);

    localparam int DW = ENC_BITS + 1;
    localparam int CW = (DW > 18) ? DW : 18;
    localparam int RW = ENC_BITS + FRAC_BITS + 2;
    localparam int XW = (RW > VAL_W + 1) ? RW : VAL_W + 1;
    localparam logic signed [CW-1:0] HOLD_C = CW'(HOLD_LIMIT);
    localparam logic signed [XW-1:0] X_MAX = {{(XW-VAL_W){1'b0}}, VAL_MAX};
    localparam logic signed [XW-1:0] X_MIN = {{(XW-VAL_W){1'b1}}, VAL_MIN};

    logic signed [VAL_W-1:0] fs_reg [2];
    logic signed [VAL_W-1:0] raw_reg [2];
    logic signed [VAL_W-1:0] dp_reg [2];
    logic signed [VAL_W-1:0] pg_reg [2];
    logic signed [VAL_W-1:0] ig_reg [2];
    logic [ENC_BITS-1:0]     pc_reg [2];
    logic signed [VAL_W-1:0] mh_reg [4];
    logic signed [VAL_W-1:0] eh_reg [4];
    logic signed [VAL_W-1:0] kps_reg [4];
    logic signed [VAL_W-1:0] kis_reg [4];

    logic [ENC_BITS-1:0]     cnt_reg [2];
    logic [SP_W-1:0]         spin_reg [2];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [VAL_W-1:0] ec_reg, ym_reg, em_reg, dkp_reg, dki_reg, t_reg;
    logic signed [VAL_W-1:0] h_reg, d1_reg, s2_reg, u_reg;
    logic [PWM_W-1:0]        pwm_st_reg [2];
    logic                    rev_st_reg [2];
    logic [SPD_W-1:0]        spd_st_reg [2];
    logic [PWM_W-1:0]        pwm_out_reg [2];
    logic                    rev_out_reg [2];
    logic [SPD_W-1:0]        spd_out_reg [2];

    logic                    w;
    logic [1:0]              i0, i1;
    uop_t                    u;
    logic signed [VAL_W-1:0] sp_cur;
    logic signed [VAL_W-1:0] a_val, b_val, term, mul_res, wv;
    logic [SH_W-1:0]         sh;
    logic signed [ACC_W-1:0] acc_next;
    logic [SPD_W-1:0]        spd_c;
    logic signed [DW-1:0]    delta;
    logic signed [CW-1:0]    delta_c;
    logic signed [XW-1:0]    d_x, d3;
    logic signed [VAL_W-1:0] raw_new;
    logic                    hold_ok;
    logic [VAL_W-1:0]        mag;
    logic [VAL_W-1:0]        mag_sh;
    logic [PWM_W-1:0]        pwm_c;

    assign w  = cmd.wheel;
    assign i0 = {w, 1'b0};
    assign i1 = {w, 1'b1};
    assign u  = uop(cmd.step);

    assign sp_cur = {{(VAL_W-SP_W){spin_reg[w][SP_W-1]}}, spin_reg[w]} <<< (FRAC_BITS - 8);

    function automatic logic signed [VAL_W-1:0] src_val(input src_t s);
        case (s)
            S_FS:     src_val = fs_reg[w];
            S_RAW:    src_val = raw_reg[w];
            S_SP:     src_val = sp_cur;
            S_MH0:    src_val = mh_reg[i0];
            S_MH1:    src_val = mh_reg[i1];
            S_EH0:    src_val = eh_reg[i0];
            S_EH1:    src_val = eh_reg[i1];
            S_KPS0:   src_val = kps_reg[i0];
            S_KPS1:   src_val = kps_reg[i1];
            S_KIS0:   src_val = kis_reg[i0];
            S_KIS1:   src_val = kis_reg[i1];
            S_PG:     src_val = pg_reg[w];
            S_IG:     src_val = ig_reg[w];
            S_DP:     src_val = dp_reg[w];
            S_EC:     src_val = ec_reg;
            S_YM:     src_val = ym_reg;
            S_EM:     src_val = em_reg;
            S_DKP:    src_val = dkp_reg;
            S_DKI:    src_val = dki_reg;
            S_T:      src_val = t_reg;
            S_H:      src_val = h_reg;
            S_D1:     src_val = d1_reg;
            S_S2:     src_val = s2_reg;
            S_ONE:    src_val = VAL_W'(1);
            S_C_FA:   src_val = C_FILT_A;
            S_C_FB:   src_val = C_FILT_B;
            S_C_M1:   src_val = C_M1;
            S_C_M2:   src_val = C_M2;
            S_C_RA:   src_val = C_REF_A;
            S_C_RB:   src_val = C_REF_B;
            S_C_KP:   src_val = C_KP;
            S_C_KIA:  src_val = C_KI_A;
            S_C_KIB:  src_val = C_KI_B;
            S_C_HALF: src_val = C_HALF_T;
            S_RATE_P: src_val = {{(VAL_W-RATE_W){1'b0}}, cfg.rate_p};
            S_RATE_I: src_val = {{(VAL_W-RATE_W){1'b0}}, cfg.rate_i};
            default:  src_val = '0;
        endcase
    endfunction

    always_comb begin
        a_val = src_val(u.a);
        b_val = src_val(u.b);
        case (u.sh)
            SHS_32:  sh = SH_W'(32);
            SHS_F:   sh = SH_W'(FRAC_BITS);
            SHS_F8:  sh = SH_W'(FRAC_BITS - 8);
            default: sh = SH_W'(32);
        endcase
    end

    apiwsc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (a_val),
        .b       (b_val),
        .sh      (sh),
        .res     (mul_res),
        .done    (mul_done)
    );

    always_comb begin
        term = u.use_mul ? mul_res : a_val;
        case (u.op)
            ACC_LOAD: acc_next = ACC_W'(term);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(term);
            ACC_SUB:  acc_next = acc_reg - ACC_W'(term);
            default:  acc_next = ACC_W'(term);
        endcase
        wv = sat48(acc_next);
        if (term > 48'sd8388607) begin
            spd_c = 24'h7FFFFF;
        end else if (term < -48'sd8388608) begin
            spd_c = 24'h800000;
        end else begin
            spd_c = term[SPD_W-1:0];
        end
    end

    // commit: raw speed, PWM split
    always_comb begin
        delta   = DW'($signed(cnt_reg[w])) - DW'($signed(pc_reg[w]));
        delta_c = CW'(delta);
        hold_ok = (delta_c > -HOLD_C) && (delta_c < HOLD_C);
        d_x     = XW'(delta);
        d3      = (d_x + (d_x <<< 1)) <<< (FRAC_BITS - 1);
        if (d3 > X_MAX) begin
            raw_new = VAL_MAX;
        end else if (d3 < X_MIN) begin
            raw_new = VAL_MIN;
        end else begin
            raw_new = d3[VAL_W-1:0];
        end
        mag    = u_reg[VAL_W-1] ? VAL_W'(-u_reg) : u_reg;
        mag_sh = mag >> FRAC_BITS;
        pwm_c  = (|mag_sh[VAL_W-1:PWM_W]) ? '1 : mag_sh[PWM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 2; j++) begin
                fs_reg[j]  <= '0;
                raw_reg[j] <= '0;
                dp_reg[j]  <= '0;
                pg_reg[j]  <= '0;
                ig_reg[j]  <= '0;
                pc_reg[j]  <= '0;
            end
            for (int j = 0; j < 4; j++) begin
                mh_reg[j]  <= '0;
                eh_reg[j]  <= '0;
                kps_reg[j] <= '0;
                kis_reg[j] <= '0;
            end
        end else begin
            if (cfg.load_kp) begin
                pg_reg[0] <= cfg.kp_start;
                pg_reg[1] <= cfg.kp_start;
            end
            if (cfg.load_ki) begin
                ig_reg[0] <= cfg.ki_start;
                ig_reg[1] <= cfg.ki_start;
            end
            if (cmd.apply) begin
                case (u.dst)
                    D_FS:    fs_reg[w] <= wv;
                    D_PG:    pg_reg[w] <= wv;
                    D_IG:    ig_reg[w] <= wv;
                    default: ;
                endcase
            end
            if (cmd.commit) begin
                if (hold_ok) begin
                    raw_reg[w] <= raw_new;
                end
                pc_reg[w]   <= cnt_reg[w];
                dp_reg[w]   <= (spin_reg[w] == '0) ? '0 : u_reg;
                eh_reg[i1]  <= eh_reg[i0];
                eh_reg[i0]  <= ec_reg;
                mh_reg[i1]  <= mh_reg[i0];
                mh_reg[i0]  <= ym_reg;
                kps_reg[i1] <= kps_reg[i0];
                kps_reg[i0] <= dkp_reg;
                kis_reg[i1] <= kis_reg[i0];
                kis_reg[i0] <= dki_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cnt_reg[0]  <= enc_count_left;
            cnt_reg[1]  <= enc_count_right;
            spin_reg[0] <= setpoint_left;
            spin_reg[1] <= setpoint_right;
        end
        if (cmd.apply) begin
            acc_reg <= acc_next;
            case (u.dst)
                D_EC:    ec_reg  <= wv;
                D_YM:    ym_reg  <= wv;
                D_EM:    em_reg  <= wv;
                D_DKP:   dkp_reg <= wv;
                D_DKI:   dki_reg <= wv;
                D_T:     t_reg   <= wv;
                D_H:     h_reg   <= wv;
                D_D1:    d1_reg  <= wv;
                D_S2:    s2_reg  <= wv;
                D_U:     u_reg   <= wv;
                D_SPD:   spd_st_reg[w] <= spd_c;
                default: ;
            endcase
        end
        if (cmd.commit) begin
            pwm_st_reg[w] <= pwm_c;
            rev_st_reg[w] <= u_reg[VAL_W-1];
        end
        if (cmd.out_load) begin
            for (int j = 0; j < 2; j++) begin
                pwm_out_reg[j] <= pwm_st_reg[j];
                rev_out_reg[j] <= rev_st_reg[j];
                spd_out_reg[j] <= spd_st_reg[j];
            end
        end
    end

    assign pwm_left      = pwm_out_reg[0];
    assign reverse_left  = rev_out_reg[0];
    assign speed_left    = spd_out_reg[0];
    assign pwm_right     = pwm_out_reg[1];
    assign reverse_right = rev_out_reg[1];
    assign speed_right   = spd_out_reg[1];

endmodule

>>> rtl/apiwsc_ctrl.sv
`timescale 1ns / 1ps
module apiwsc_ctrl
    import apiwsc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic mul_done,
    output cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              wheel_reg, wheel_next;
    logic              m_valid_reg, m_valid_next;
    logic              adv;
    uop_t              u;

    assign u = uop(step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            wheel_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            wheel_reg   <= wheel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        wheel_next = wheel_reg;
        cmd        = '0;
        cmd.wheel  = wheel_reg;
        cmd.step   = step_reg;
        s_tready   = 1'b0;
        adv        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    wheel_next  = 1'b0;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (u.use_mul) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_WAIT;
                end else begin
                    cmd.apply = 1'b1;
                    adv       = 1'b1;
                end
            end
            ST_WAIT: begin
                if (mul_done) begin
                    cmd.apply = 1'b1;
                    adv       = 1'b1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (!wheel_reg) begin
                    wheel_next = 1'b1;
                    step_next  = '0;
                    state_next = ST_ISSUE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (adv) begin
            if (step_reg == STEP_W'(LAST_STEP)) begin
                state_next = ST_COMMIT;
            end else begin
                step_next  = step_reg + STEP_W'(1);
                state_next = ST_ISSUE;
            end
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result not presented after load");

    a_capture_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_ISSUE && step_reg == '0 && !wheel_reg))
        else $error("sequence did not restart on new item");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_W'(LAST_STEP))
        else $error("step counter out of range");

    a_second_wheel: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && wheel_reg) |=> state_reg == ST_HOLD)
        else $error("missed result hold after second wheel");

endmodule

>>> rtl/adaptive_pi_wheel_speed_control_core.sv
`timescale 1ns / 1ps
// Two-wheel adaptive PI speed controller (MIT-rule gain adaptation).
// Input channel s_*: one item per control tick carrying both encoder counts
// and both setpoints (rpm, Q8). Result channel m_*: PWM magnitude, reverse
// flag and filtered speed for both wheels, one result per input item.
// Gains and adaptation rates are set over the APB port at byte address 8*i;
// writing kp_start or ki_start also reloads both wheels' gain.
// One item is processed at a time. A single shared multiplier (48x16 per
// cycle, rounding and saturation as further steps) runs 22 products per
// wheel, plus 11 add/sub steps and a commit step. s_tready returns the
// cycle after the result is loaded, so a new item is taken only once the
// last one is through. A finished result sits in the
// output register while the next item is taken; if the receiver still holds
// off when the next result is done, the block waits with s_tready low until
// m_tready frees the register.
// Reset (aresetn low, synchronous) clears all filter, model and sensitivity
// history, zeroes stored drive, counts and both wheels' gains, and resets
// the kp_start and ki_start registers to 0.
module adaptive_pi_wheel_speed_control_core
    import apiwsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ENC_BITS  = ENC_BITS_DEF,
    localparam int S_FIELDS_W = 2 * ENC_BITS + 2 * SP_W,
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [CFG_W-1:0]    pwdata,
    output logic [CFG_W-1:0]    prdata,
    output logic                pready,
    input  logic                s_tvalid,
    output logic                s_tready,
    // enc_count_left, enc_count_right, setpoint_left, setpoint_right
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pwm_left, reverse_left, pwm_right, reverse_right, speed_left, speed_right
    output logic [M_DATA_W-1:0] m_tdata
);

    cfg_t             cfg;
    cmd_t             cmd;
    logic             mul_done;
    logic [PWM_W-1:0] pwm_l, pwm_r;
    logic             rev_l, rev_r;
    logic [SPD_W-1:0] spd_l, spd_r;

    apiwsc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apiwsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .mul_done (mul_done),
        .cmd      (cmd)
    );

    apiwsc_dp #(
        .FRAC_BITS (FRAC_BITS),
        .ENC_BITS  (ENC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg             (cfg),
        .enc_count_left  (s_tdata[ENC_BITS-1:0]),
        .enc_count_right (s_tdata[2*ENC_BITS-1:ENC_BITS]),
        .setpoint_left   (s_tdata[2*ENC_BITS+SP_W-1:2*ENC_BITS]),
        .setpoint_right  (s_tdata[2*ENC_BITS+2*SP_W-1:2*ENC_BITS+SP_W]),
        .mul_done        (mul_done),
        .pwm_left        (pwm_l),
        .reverse_left    (rev_l),
        .pwm_right       (pwm_r),
        .reverse_right   (rev_r),
        .speed_left      (spd_l),
        .speed_right     (spd_r)
    );

    assign m_tdata = {{(M_DATA_W - 2*PWM_W - 2 - 2*SPD_W){1'b0}},
                      spd_r, spd_l, rev_r, pwm_r, rev_l, pwm_l};

endmodule

>>> tb/sv/adaptive_pi_wheel_speed_control_core_tb.sv
`timescale 1ns / 1ps
module adaptive_pi_wheel_speed_control_core_tb;
    import apiwsc_pkg::*;

    localparam int S_DATA_W  = 80;
    localparam int N_RANDOM  = 830;
    localparam int CYC_LIMIT = 2000000;
    localparam longint LIM = 64'sh7FFF_FFFF_FFFF;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [CFG_W-1:0]    pwdata = '0;
    logic [CFG_W-1:0]    prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // enc_count_left, enc_count_right, setpoint_left, setpoint_right
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // pwm_left, reverse_left, pwm_right, reverse_right, speed_left, speed_right
    logic [M_DATA_W-1:0] m_tdata;

    adaptive_pi_wheel_speed_control_core u_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    typedef struct packed {
        logic [23:0] spd_r;
        logic [23:0] spd_l;
        logic        rev_r;
        logic [15:0] pwm_r;
        logic        rev_l;
        logic [15:0] pwm_l;
    } drive_t;

    typedef struct {
        logic [15:0] cnt_l;
        logic [15:0] cnt_r;
        logic [23:0] sp_l;
        logic [23:0] sp_r;
        bit          known;
        drive_t      want;
    } tick_t;

    // controller state per wheel
    longint kp_init, ki_init, rate_p, rate_i;
    longint last_cnt[2], raw_spd[2], filt_spd[2], drive_mem[2], kp_g[2], ki_g[2];
    longint mdl_h[4], err_h[4], kps_h[4], kis_h[4];

    drive_t pending_drive[$];
    drive_t fixed_drive[$];
    bit     fixed_known[$];
    tick_t  ticks[$];
    int     n_err = 0;
    longint cyc = 0;
    bit     hold_off = 1'b0;
    int     rx_gap = 0;

    function automatic longint sat48(longint v);
        if (v > LIM) return LIM;
        if (v < -LIM - 1) return -LIM - 1;
        return v;
    endfunction

    function automatic longint rmul(longint a, longint b, int sh);
        logic signed [127:0] p;
        logic [127:0]        m;
        bit                  neg;
        p = 128'(signed'(a)) * 128'(signed'(b));
        neg = p < 0;
        m = neg ? -p : p;
        if (sh > 0) m = (m + (128'd1 << (sh - 1))) >> sh;
        if (!neg && m > 128'(LIM)) return LIM;
        if (neg && m > 128'(LIM) + 1) return -LIM - 1;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint sum48(longint a, longint b);
        logic signed [65:0] s;
        s = 66'(signed'(a)) + 66'(signed'(b));
        if (s > LIM) return LIM;
        if (s < -LIM - 1) return -LIM - 1;
        return longint'(s);
    endfunction

    function automatic void run_wheel(input int w, input logic [15:0] cnt_in,
                                      input logic [23:0] sp_in, output logic [15:0] pwm,
                                      output logic rev, output logic [23:0] spd);
        longint cnt, delta, sp, e1, e2, filt, ec, ym, em, dkp, dki, u, s, mag;
        cnt = longint'(signed'(cnt_in));
        delta = cnt - last_cnt[w];
        sp = longint'(signed'(sp_in)) * (64'sd1 << 16);
        e1 = err_h[2*w];
        e2 = err_h[2*w+1];
        filt = sum48(rmul(longint'(C_FILT_A), filt_spd[w], 32),
                     rmul(longint'(C_FILT_B), raw_spd[w], 32));
        if (delta > -40000 && delta < 40000) raw_spd[w] = sat48(delta * 3 * (64'sd1 << 23));
        last_cnt[w] = cnt;
        filt_spd[w] = filt;
        ec = sum48(sp, -filt);
        ym = sat48(rmul(longint'(C_REF_A), sp, 32) + rmul(longint'(C_REF_B), sp, 32) +
                   rmul(longint'(C_M1), mdl_h[2*w], 32) -
                   rmul(longint'(C_M2), mdl_h[2*w+1], 32));
        em = sum48(filt, -ym);
        dkp = sat48(rmul(longint'(C_M1), kps_h[2*w], 32) -
                    rmul(longint'(C_M2), kps_h[2*w+1], 32) +
                    rmul(longint'(C_KP), e1, 32) - rmul(longint'(C_KP), e2, 32));
        kp_g[w] = sum48(kp_g[w], -rmul(rate_p, rmul(em, dkp, 24), 32));
        dki = sat48(rmul(longint'(C_M1), kis_h[2*w], 32) -
                    rmul(longint'(C_M2), kis_h[2*w+1], 32) +
                    rmul(longint'(C_KI_A), e1, 32) + rmul(longint'(C_KI_B), e2, 32));
        ki_g[w] = sum48(ki_g[w], -rmul(rate_i, rmul(em, dki, 24), 32));
        u = sat48(drive_mem[w] + rmul(kp_g[w], sum48(ec, -e1), 24) +
                  rmul(rmul(longint'(C_HALF_T), ki_g[w], 32), sum48(ec, e1), 24));
        rev = u < 0;
        mag = (u < 0 ? -u : u) >>> 24;
        pwm = mag > 65535 ? 16'hFFFF : mag[15:0];
        s = rmul(filt, 1, 16);
        if (s > 8388607) s = 8388607;
        if (s < -8388608) s = -8388608;
        spd = s[23:0];
        drive_mem[w] = (sp_in == 0) ? 0 : u;
        err_h[2*w+1] = e1;              err_h[2*w] = ec;
        mdl_h[2*w+1] = mdl_h[2*w];      mdl_h[2*w] = ym;
        kps_h[2*w+1] = kps_h[2*w];      kps_h[2*w] = dkp;
        kis_h[2*w+1] = kis_h[2*w];      kis_h[2*w] = dki;
    endfunction

    function automatic drive_t predict_drive(tick_t t);
        drive_t d;
        run_wheel(0, t.cnt_l, t.sp_l, d.pwm_l, d.rev_l, d.spd_l);
        run_wheel(1, t.cnt_r, t.sp_r, d.pwm_r, d.rev_r, d.spd_r);
        return d;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        n_err++;
        $display("ERROR %0s got %0h want %0h at cycle %0d", what, got, want, cyc);
    endtask

    task automatic reset_state();
        kp_init = 0; ki_init = 0; rate_p = 214748; rate_i = 214748;
        for (int i = 0; i < 2; i++) begin
            last_cnt[i] = 0; raw_spd[i] = 0; filt_spd[i] = 0; drive_mem[i] = 0;
            kp_g[i] = 0; ki_g[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            mdl_h[i] = 0; err_h[i] = 0; kps_h[i] = 0; kis_h[i] = 0;
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(8 * int'(idx)); pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_KP_START: begin
                kp_init = longint'(signed'(v[47:0])); kp_g[0] = kp_init; kp_g[1] = kp_init;
            end
            REG_KI_START: begin
                ki_init = longint'(signed'(v[47:0])); ki_g[0] = ki_init; ki_g[1] = ki_init;
            end
            REG_RATE_P: rate_p = longint'(v[31:0]);
            REG_RATE_I: rate_i = longint'(v[31:0]);
            default: ;
        endcase
    endtask

    task automatic send_tick(input tick_t t);
        drive_t d;
        int     gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        d = predict_drive(t);
        pending_drive.push_back(d);
        fixed_drive.push_back(t.want);
        fixed_known.push_back(t.known);
        s_tvalid <= 1'b1;
        s_tdata <= {t.sp_r, t.sp_l, t.cnt_r, t.cnt_l};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_offer();
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_drive.size() != 0 && cyc < CYC_LIMIT) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic tick_t mk(logic [15:0] cl, logic [15:0] cr, logic [23:0] sl,
                                 logic [23:0] sr);
        tick_t t;
        t.cnt_l = cl; t.cnt_r = cr; t.sp_l = sl; t.sp_r = sr;
        t.known = 1'b0; t.want = '0;
        return t;
    endfunction

    function automatic tick_t rand_tick(logic [15:0] base_l, logic [15:0] base_r);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return mk(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
        return mk(base_l + 16'($urandom_range(0, 400)) - 16'd200,
                  base_r + 16'($urandom_range(0, 400)) - 16'd200,
                  (k == 1) ? 24'd0 : 24'($urandom_range(0, 120000)) - 24'd60000,
                  (k == 2) ? 24'd0 : 24'($urandom_range(0, 120000)) - 24'd60000);
    endfunction

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYC_LIMIT) begin
            $display("FAIL adaptive_pi_wheel_speed_control_core");
            $finish;
        end
    end

    always @(posedge aclk) begin
        int g;
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            g = $urandom_range(0, 8);
            m_tready <= (g == 0);
            rx_gap   <= (g == 0) ? 0 : g - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        drive_t got, want, fx;
        bit     fk;
        if (aresetn && m_tvalid && m_tready) begin
            got = drive_t'(m_tdata[81:0]);
            if (pending_drive.size() == 0) begin
                report("unexpected item", longint'(got[63:0]), 0);
            end else begin
                want = pending_drive.pop_front();
                fx = fixed_drive.pop_front();
                fk = fixed_known.pop_front();
                if (fk && fx != got)
                    report("table row", longint'(got[63:0]), longint'(fx[63:0]));
                if (got.pwm_l != want.pwm_l)
                    report("pwm_left", longint'(got.pwm_l), longint'(want.pwm_l));
                if (got.rev_l != want.rev_l)
                    report("reverse_left", longint'(got.rev_l), longint'(want.rev_l));
                if (got.pwm_r != want.pwm_r)
                    report("pwm_right", longint'(got.pwm_r), longint'(want.pwm_r));
                if (got.rev_r != want.rev_r)
                    report("reverse_right", longint'(got.rev_r), longint'(want.rev_r));
                if (got.spd_l != want.spd_l)
                    report("speed_left", longint'(got.spd_l), longint'(want.spd_l));
                if (got.spd_r != want.spd_r)
                    report("speed_right", longint'(got.spd_r), longint'(want.spd_r));
            end
        end
    end

    initial begin
        tick_t       table_rows[$];
        tick_t       t;
        logic [15:0] bl, br;
        reset_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // after reset, zero gains: zero drive, zero speed
        t = mk(16'd0, 16'd0, 24'd0, 24'd0); t.known = 1'b1; table_rows.push_back(t);
        t = mk(16'd100, 16'hFF9C, 24'd25600, 24'hFF9C00); t.known = 1'b1;
        table_rows.push_back(t);
        table_rows.push_back(mk(16'h7FFF, 16'h8000, 24'h7FFFFF, 24'h800000));
        table_rows.push_back(mk(16'h8000, 16'h7FFF, 24'h800000, 24'h7FFFFF));
        table_rows.push_back(mk(16'h8000, 16'h7FFF, 24'd0, 24'd0));
        table_rows.push_back(mk(16'hFFFF, 16'h0000, 24'hFFFFFF, 24'd1));
        table_rows.push_back(mk(16'd200, 16'd300, 24'd12800, 24'd0));
        table_rows.push_back(mk(16'd400, 16'd500, 24'd12800, 24'd25600));
        foreach (table_rows[i]) send_tick(table_rows[i]);
        stop_offer();
        drain();

        write_reg(REG_KP_START, 64'h0000_0000_0100_0000);
        write_reg(REG_KI_START, 64'h0000_0000_0080_0000);
        write_reg(REG_RATE_P, 64'hFFFF_FFFF);
        write_reg(REG_RATE_I, 64'd0);
        for (int i = 0; i < 10; i++)
            send_tick(mk(16'(i * 150), 16'(i * 90), 24'd30000, 24'hFF0000));
        send_tick(mk(16'h7FFF, 16'h8000, 24'h7FFFFF, 24'h800000));
        send_tick(mk(16'h0000, 16'h0000, 24'd0, 24'd0));
        stop_offer();
        drain();

        write_reg(REG_KP_START, 64'h0000_7FFF_FFFF_FFFF);
        write_reg(REG_KI_START, 64'h0000_8000_0000_0000);
        write_reg(REG_RATE_P, 64'd214748);
        write_reg(REG_RATE_I, 64'hFFFF_FFFF);
        for (int i = 0; i < 5; i++)
            send_tick(mk(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom)));

        // long receiver hold-off so the block stalls its input
        hold_off <= 1'b1;
        fork
            begin
                repeat (1500) @(posedge aclk);
                hold_off <= 1'b0;
            end
            begin
                for (int i = 0; i < 5; i++)
                    send_tick(mk(16'($urandom), 16'($urandom), 24'd5000, 24'd5000));
                stop_offer();
            end
        join
        drain();

        bl = 16'd0; br = 16'd0;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_KP_START, {16'd0, 48'($urandom_range(0, 1 << 26))});
            write_reg(REG_KI_START, {16'd0, 48'($urandom_range(0, 1 << 24))});
            write_reg(REG_RATE_P, 64'($urandom_range(0, 2000000)));
            write_reg(REG_RATE_I, 64'($urandom_range(0, 2000000)));
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                t = rand_tick(bl, br);
                bl = t.cnt_l; br = t.cnt_r;
                send_tick(t);
            end
            stop_offer();
            drain();
        end
        drain();
        if (n_err == 0 && pending_drive.size() == 0) begin
            $display("PASS adaptive_pi_wheel_speed_control_core");
        end else begin
            $display("FAIL adaptive_pi_wheel_speed_control_core");
        end
        $finish;
    end
endmodule
